// ===== sv/osm_pkg.sv =====
// Shared types and codes for the offset sorted multiset.
package osm_pkg;

    localparam logic [2:0] FUNC_ADD    = 3'd0;
    localparam logic [2:0] FUNC_OFFSET = 3'd1;
    localparam logic [2:0] FUNC_ERASE  = 3'd2;
    localparam logic [2:0] FUNC_COUNT  = 3'd3;
    localparam logic [2:0] FUNC_POPHI  = 3'd4;
    localparam logic [2:0] FUNC_POPLO  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRD,
        S_SCMP,
        S_DECIDE,
        S_MRD,
        S_MWR,
        S_PUT,
        S_PRD,
        S_PCHK,
        S_PFIN,
        S_XRD,
        S_XHI,
        S_XLO,
        S_RESULT
    } t_state;

    function automatic logic key_less(input logic [63:0] a, input logic [63:0] b);
        key_less = $signed(a) < $signed(b);
    endfunction

endpackage

// ===== sv/osm_mem.sv =====
// Entry memory: key and count per slot, one write and one registered read.
module osm_mem import osm_pkg::*; #(
    parameter int CAPACITY = 64,
    parameter int AW       = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wkey,
    input  logic [31:0]   i_wcnt,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rkey,
    output logic [31:0]   o_rcnt
);

    logic [95:0] r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wcnt, i_wkey};
        end
        {o_rcnt, o_rkey} <= r_mem[i_raddr];
    end

endmodule

// ===== sv/offset_sorted_multiset.sv =====
// Top level of the offset sorted multiset: sequencer around one entry memory.
// channel | dir | handshake                   | fields, lowest bit first
// s_axis  | in  | s_axis_tvalid/s_axis_tready | tdata: key, amount; tuser: func
// m_axis  | out | m_axis_tvalid/m_axis_tready | tdata: value_count, high_key, high_count,
//         |     |                             |   low_key, low_count, is_empty; tuser: status
// All table work goes through one memory port with a registered read: an entry searched
// takes S_SRD and S_SCMP, an entry moved S_MRD and S_MWR, an entry popped S_PRD and S_PCHK,
// then the extremes are read in S_XRD, S_XHI and S_XLO.
// Synchronous active-low reset clears occupancy, offset and control; no memory clear.
// Input is not ready while an item is at work or its result waits on m_axis_tready.
module offset_sorted_multiset import osm_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [63:0]   s_axis_tdata,   // key[31:0], amount[63:32]
    input  logic [2:0]    s_axis_tuser,   // func
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [231:0]  m_axis_tdata,   // value_count, high_key, high_count, low_key,
                                          // low_count, is_empty, zero fill
    output logic [1:0]    m_axis_tuser    // status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int OW = $clog2(CAPACITY + 1);

    t_state        r_state, n_state;
    logic [2:0]    r_func;
    logic [63:0]   r_s;
    logic [31:0]   r_amt;
    logic [31:0]   r_want;
    logic [OW-1:0] r_occ, r_idx, r_pos, r_gap;
    logic [63:0]   r_off;
    logic          r_found;
    logic          r_up;
    logic [31:0]   r_pcnt;
    logic [31:0]   r_value;
    logic [1:0]    r_status;
    logic [63:0]   r_hk, r_lk;
    logic [31:0]   r_hc, r_lc;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [63:0]   mem_wkey, mem_rkey;
    logic [31:0]   mem_wcnt, mem_rcnt;

    logic [63:0]   in_key;
    logic          in_pop;
    logic          in_search;
    logic          is_less;
    logic [32:0]   addsum;
    logic [31:0]   addsat;
    logic [31:0]   want_eff;
    logic [OW-1:0] last_idx, popidx, avail, up_dst, dn_dst;
    logic          emp;

    osm_mem #(.CAPACITY(CAPACITY), .AW(AW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wkey (mem_wkey),
        .i_wcnt (mem_wcnt),
        .i_raddr(mem_raddr),
        .o_rkey (mem_rkey),
        .o_rcnt (mem_rcnt)
    );

    assign in_key    = {{32{s_axis_tdata[31]}}, s_axis_tdata[31:0]};
    assign in_pop    = s_axis_tuser inside {FUNC_POPHI, FUNC_POPLO};
    assign in_search = s_axis_tuser inside {FUNC_ADD, FUNC_ERASE, FUNC_COUNT};
    assign is_less   = key_less(mem_rkey, r_s);
    assign addsum    = {1'b0, r_pcnt} + {1'b0, r_amt};
    assign addsat    = addsum[32] ? 32'hFFFF_FFFF : addsum[31:0];
    assign want_eff  = (r_want == '0) ? mem_rcnt : r_want;
    assign last_idx  = r_occ - OW'(1);
    assign popidx    = (r_func == FUNC_POPHI) ? last_idx : r_gap;
    assign avail     = r_occ - r_gap;
    assign up_dst    = r_idx + OW'(1);
    assign dn_dst    = r_idx - r_gap;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (in_search) n_state = S_SRD;
                    else if (in_pop && r_occ != '0) n_state = S_PRD;
                    else n_state = S_XRD;
                end
            end
            S_SRD:    n_state = (r_idx >= r_occ) ? S_DECIDE : S_SCMP;
            S_SCMP:   n_state = is_less ? S_SRD : S_DECIDE;
            S_DECIDE: begin
                n_state = S_XRD;
                if (r_func == FUNC_ADD) begin
                    if (r_found) n_state = S_PUT;
                    else if (r_amt != '0 && r_occ < OW'(CAPACITY))
                        n_state = (r_idx == r_occ) ? S_PUT : S_MRD;
                end else if (r_func == FUNC_ERASE && r_found) begin
                    n_state = S_MRD;
                end
            end
            S_MRD:    n_state = (!r_up && r_idx >= r_occ) ? S_XRD : S_MWR;
            S_MWR:    n_state = (r_up && r_idx == r_pos) ? S_PUT : S_MRD;
            S_PUT:    n_state = (r_func inside {FUNC_POPHI, FUNC_POPLO}) ? S_PFIN : S_XRD;
            S_PRD:    n_state = (avail == '0) ? S_PFIN : S_PCHK;
            S_PCHK: begin
                if (mem_rcnt > want_eff) n_state = S_PUT;
                else if (mem_rcnt == want_eff) n_state = S_PFIN;
                else n_state = S_PRD;
            end
            S_PFIN:   n_state = (r_func == FUNC_POPLO && r_gap != '0) ? S_MRD : S_XRD;
            S_XRD:    n_state = (r_occ == '0) ? S_RESULT : S_XHI;
            S_XHI:    n_state = S_XLO;
            S_XLO:    n_state = S_RESULT;
            S_RESULT: if (m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        m_axis_tvalid = (r_state == S_RESULT);
        mem_raddr = r_idx[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = r_pos[AW-1:0];
        mem_wkey  = mem_rkey;
        mem_wcnt  = mem_rcnt;
        unique case (r_state)
            S_PRD: mem_raddr = popidx[AW-1:0];
            S_XRD: mem_raddr = last_idx[AW-1:0];
            S_XHI: mem_raddr = '0;
            S_MWR: begin
                mem_we    = 1'b1;
                mem_waddr = r_up ? up_dst[AW-1:0] : dn_dst[AW-1:0];
            end
            S_PUT: begin
                mem_we   = 1'b1;
                mem_wkey = r_s;
                mem_wcnt = r_pcnt;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_occ    <= '0;
            r_off    <= '0;
            r_value  <= '0;
            r_status <= ST_OK;
            r_hk     <= '0;
            r_hc     <= '0;
            r_lk     <= '0;
            r_lc     <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_func   <= s_axis_tuser;
                        r_s      <= in_key - r_off;
                        r_amt    <= s_axis_tdata[63:32];
                        r_want   <= s_axis_tdata[63:32];
                        r_idx    <= '0;
                        r_gap    <= '0;
                        r_found  <= 1'b0;
                        r_up     <= 1'b0;
                        r_value  <= '0;
                        r_status <= (in_pop && r_occ == '0) ? ST_EMPTY : ST_OK;
                        if (s_axis_tuser == FUNC_OFFSET) r_off <= r_off + in_key;
                    end
                end
                S_SRD: ;
                S_SCMP: begin
                    if (is_less) begin
                        r_idx <= up_dst;
                    end else begin
                        r_found <= (mem_rkey == r_s);
                        r_pcnt  <= mem_rcnt;
                    end
                end
                S_DECIDE: begin
                    r_pos <= r_idx;
                    if (r_func == FUNC_COUNT) begin
                        if (r_found) r_value <= r_pcnt;
                    end else if (r_func == FUNC_ERASE) begin
                        if (r_found) begin
                            r_value <= r_pcnt;
                            r_idx   <= up_dst;
                            r_gap   <= OW'(1);
                        end
                    end else if (r_func == FUNC_ADD) begin
                        if (r_found) begin
                            r_value <= addsat;
                            r_pcnt  <= addsat;
                        end else if (r_amt != '0) begin
                            if (r_occ >= OW'(CAPACITY)) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_value <= r_amt;
                                r_pcnt  <= r_amt;
                                r_idx   <= last_idx;
                                r_up    <= 1'b1;
                                r_occ   <= r_occ + OW'(1);
                            end
                        end
                    end
                end
                S_MRD: begin
                    if (!r_up && r_idx >= r_occ) r_occ <= r_occ - r_gap;
                end
                S_MWR: begin
                    if (!r_up) r_idx <= up_dst;
                    else if (r_idx != r_pos) r_idx <= r_idx - OW'(1);
                end
                S_PUT: ;
                S_PRD: begin
                    if (avail == '0) r_status <= ST_EMPTY;
                end
                S_PCHK: begin
                    if (mem_rcnt > want_eff) begin
                        r_pcnt  <= mem_rcnt - want_eff;
                        r_pos   <= popidx;
                        r_s     <= mem_rkey;
                        r_value <= r_value + want_eff;
                    end else begin
                        r_value <= r_value + mem_rcnt;
                        r_want  <= want_eff - mem_rcnt;
                        if (r_func == FUNC_POPHI) r_occ <= last_idx;
                        else r_gap <= r_gap + OW'(1);
                    end
                end
                S_PFIN: r_idx <= r_gap;
                S_XRD: ;
                S_XHI: begin
                    r_hk <= mem_rkey + r_off;
                    r_hc <= mem_rcnt;
                end
                S_XLO: begin
                    r_lk <= mem_rkey + r_off;
                    r_lc <= mem_rcnt;
                end
                S_RESULT: ;
                default: ;
            endcase
        end
    end

    assign emp = (r_occ == '0);
    assign m_axis_tuser = r_status;
    assign m_axis_tdata = {7'd0, emp,
                           emp ? 32'd0 : r_lc, emp ? 64'd0 : r_lk,
                           emp ? 32'd0 : r_hc, emp ? 64'd0 : r_hk, r_value};

endmodule

// ===== sv/osm_checker.sv =====
// Port-level checker for the offset sorted multiset, bound to the top level.
module osm_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [231:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[224] |-> m_axis_tdata[223:32] == '0)
        else $error("empty result with extremes");

    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3) else $error("bad status");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");

endmodule

bind offset_sorted_multiset osm_checker u_osm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);

// ===== dv/offset_sorted_multiset_check.sv =====
// Checker for the offset sorted multiset: predicts each result and compares it.
`timescale 1ns / 100ps
module offset_sorted_multiset_check import osm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    input  logic          s_axis_tready,
    input  logic [63:0]   s_axis_tdata,   // key[31:0], amount[63:32]
    input  logic [2:0]    s_axis_tuser,   // func
    input  logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  logic [231:0]  m_axis_tdata,   // value_count, high_key, high_count, low_key,
                                          // low_count, is_empty, zero fill
    input  logic [1:0]    m_axis_tuser,   // status
    output int            o_fail_count,
    output int            o_pending
);

    localparam int CAPACITY = 64;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_count;
        logic [63:0] high_key;
        logic [31:0] high_count;
        logic [63:0] low_key;
        logic [31:0] low_count;
        logic        is_empty;
    } t_result;

    logic [63:0] set_keys[$];
    logic [31:0] set_counts[$];
    logic [63:0] key_offset;
    t_result     expected_results[$];

    task automatic pop_end(input bit from_top, input logic [31:0] amt,
                           output logic [31:0] removed, inout logic [1:0] status);
        longint unsigned want;
        longint unsigned taken;
        longint unsigned c;
        int idx;
        taken = 0;
        if (set_keys.size() == 0) begin
            status = ST_EMPTY;
            removed = '0;
            return;
        end
        want = (amt == 0) ? set_counts[from_top ? set_keys.size() - 1 : 0] : amt;
        while (want > 0) begin
            if (set_keys.size() == 0) begin
                status = ST_EMPTY;
                break;
            end
            idx = from_top ? set_keys.size() - 1 : 0;
            c = set_counts[idx];
            if (c > want) begin
                set_counts[idx] = 32'(c - want);
                taken += want;
                want = 0;
            end else begin
                set_keys.delete(idx);
                set_counts.delete(idx);
                taken += c;
                want -= c;
            end
        end
        removed = taken[31:0];
    endtask

    task automatic predict_op(input logic [2:0] fn, input logic [31:0] key32,
                              input logic [31:0] amt, output t_result r);
        logic [63:0] kx;
        logic [63:0] stored;
        longint unsigned total;
        int pos;
        bit found;
        int last;
        kx = {{32{key32[31]}}, key32};
        stored = kx - key_offset;
        pos = 0;
        while (pos < set_keys.size() && $signed(set_keys[pos]) < $signed(stored))
            pos++;
        found = pos < set_keys.size() && set_keys[pos] == stored;
        r = '0;
        case (fn)
            FUNC_ADD: begin
                if (found) begin
                    total = longint'(set_counts[pos]) + amt;
                    if (total > 64'hFFFF_FFFF)
                        total = 64'hFFFF_FFFF;
                    set_counts[pos] = total[31:0];
                    r.value_count = total[31:0];
                end else if (amt == 0) begin
                    r.value_count = '0;
                end else if (set_keys.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    set_keys.insert(pos, stored);
                    set_counts.insert(pos, amt);
                    r.value_count = amt;
                end
            end
            FUNC_OFFSET: key_offset = key_offset + kx;
            FUNC_ERASE: begin
                if (found) begin
                    r.value_count = set_counts[pos];
                    set_keys.delete(pos);
                    set_counts.delete(pos);
                end
            end
            FUNC_COUNT: if (found) r.value_count = set_counts[pos];
            FUNC_POPHI: pop_end(1'b1, amt, r.value_count, r.status);
            FUNC_POPLO: pop_end(1'b0, amt, r.value_count, r.status);
            default: ;
        endcase
        if (set_keys.size() == 0) begin
            r.is_empty = 1'b1;
        end else begin
            last = set_keys.size() - 1;
            r.high_key = set_keys[last] + key_offset;
            r.high_count = set_counts[last];
            r.low_key = set_keys[0] + key_offset;
            r.low_count = set_counts[0];
        end
    endtask

    task automatic compare(input t_result e, input t_result a);
        if (a.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, a.status);
            o_fail_count++;
        end
        if (a.value_count !== e.value_count) begin
            $error("value_count expected %0h actual %0h", e.value_count, a.value_count);
            o_fail_count++;
        end
        if (a.high_key !== e.high_key) begin
            $error("high_key expected %0h actual %0h", e.high_key, a.high_key);
            o_fail_count++;
        end
        if (a.high_count !== e.high_count) begin
            $error("high_count expected %0h actual %0h", e.high_count, a.high_count);
            o_fail_count++;
        end
        if (a.low_key !== e.low_key) begin
            $error("low_key expected %0h actual %0h", e.low_key, a.low_key);
            o_fail_count++;
        end
        if (a.low_count !== e.low_count) begin
            $error("low_count expected %0h actual %0h", e.low_count, a.low_count);
            o_fail_count++;
        end
        if (a.is_empty !== e.is_empty) begin
            $error("is_empty expected %0d actual %0d", e.is_empty, a.is_empty);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        key_offset = '0;
    end

    always @(posedge i_clk) begin
        t_result r;
        t_result got;
        if (!i_rst_n) begin
            set_keys.delete();
            set_counts.delete();
            key_offset = '0;
            expected_results.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_op(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32], r);
                expected_results.push_back(r);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tuser;
                got.value_count = m_axis_tdata[31:0];
                got.high_key = m_axis_tdata[95:32];
                got.high_count = m_axis_tdata[127:96];
                got.low_key = m_axis_tdata[191:128];
                got.low_count = m_axis_tdata[223:192];
                got.is_empty = m_axis_tdata[224];
                if (expected_results.size() == 0) begin
                    $error("result item with no expectation waiting");
                    o_fail_count++;
                end else begin
                    compare(expected_results.pop_front(), got);
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== dv/offset_sorted_multiset_test.sv =====
// Testbench top for the offset sorted multiset: stimulus, idling and verdict.
`timescale 1ns / 100ps
module offset_sorted_multiset_test import osm_pkg::*;;

    localparam logic [2:0] FUNC_NOP6 = 3'd6;
    localparam logic [2:0] FUNC_NOP7 = 3'd7;
    localparam int RANDOM_ITEMS = 1000;
    localparam int QUIET_ITEMS = 150;
    localparam int CYCLE_LIMIT = 2000000;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [63:0]   s_axis_tdata;   // key[31:0], amount[63:32]
    logic [2:0]    s_axis_tuser;   // func
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [231:0]  m_axis_tdata;   // value_count, high_key, high_count, low_key,
                                   // low_count, is_empty, zero fill
    logic [1:0]    m_axis_tuser;   // status
    int            fail_count;
    int            pending;
    bit            quiet;
    bit            hold_req;
    int            cycle_count;

    offset_sorted_multiset DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    offset_sorted_multiset_check checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (800) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_op(input logic [2:0] fn, input logic [31:0] key,
                           input logic [31:0] amt);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= fn;
        s_axis_tdata <= {amt, key};
        do @(posedge i_clk); while (!s_axis_tready);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 90)) - 45);
        endcase
    endfunction

    function automatic logic [31:0] pick_amount();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return $urandom();
            2: return 32'hFFFF_FFFF - $urandom_range(0, 2);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    initial begin
        logic [2:0] fn;
        logic [31:0] key;
        int r;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= FUNC_ADD;
        quiet = 1'b0;
        hold_req = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_op(FUNC_POPHI, 32'd0, 32'd5);
        send_op(FUNC_POPLO, 32'd0, 32'd0);
        send_op(FUNC_ADD, 32'd7, 32'd0);
        send_op(FUNC_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_op(FUNC_ADD, 32'h7FFF_FFFF, 32'd3);
        send_op(FUNC_ADD, 32'h8000_0000, 32'd1);
        send_op(FUNC_ADD, 32'd0, 32'd4);
        send_op(FUNC_COUNT, 32'h7FFF_FFFF, 32'd0);
        send_op(FUNC_COUNT, 32'd99, 32'd0);
        send_op(FUNC_OFFSET, 32'h7FFF_FFFF, 32'd0);
        send_op(FUNC_OFFSET, 32'h8000_0000, 32'd0);
        send_op(FUNC_ADD, 32'hFFFF_FFFF, 32'd2);
        send_op(FUNC_POPHI, 32'd0, 32'd1);
        send_op(FUNC_POPLO, 32'd0, 32'd2);
        send_op(FUNC_ERASE, 32'hFFFF_FFFF, 32'd0);
        send_op(FUNC_ERASE, 32'd1234, 32'd0);
        send_op(FUNC_NOP6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(FUNC_NOP7, 32'd0, 32'd0);
        send_op(FUNC_POPLO, 32'd0, 32'hFFFF_FFFF);
        for (int i = 0; i < 66; i++)
            send_op(FUNC_ADD, 32'(i * 3 - 90), 32'(i + 1));
        send_op(FUNC_POPHI, 32'd0, 32'd0);
        send_op(FUNC_ADD, 32'd5000, 32'd1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300)
                hold_req = 1'b1;
            if (n == 600)
                do @(posedge i_clk); while (pending != 0);
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            r = $urandom_range(0, 99);
            key = pick_key();
            if (r < 40)
                fn = FUNC_ADD;
            else if (r < 47) begin
                fn = FUNC_OFFSET;
                key = ($urandom_range(0, 4) == 0) ? $urandom()
                                                  : 32'($signed($urandom_range(0, 6)) - 3);
            end else if (r < 60)
                fn = FUNC_ERASE;
            else if (r < 70)
                fn = FUNC_COUNT;
            else if (r < 83)
                fn = FUNC_POPHI;
            else if (r < 96)
                fn = FUNC_POPLO;
            else
                fn = ($urandom_range(0, 1) == 0) ? FUNC_NOP6 : FUNC_NOP7;
            send_op(fn, key, pick_amount());
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/osm_pkg.sv
sv/osm_mem.sv
sv/offset_sorted_multiset.sv
sv/osm_checker.sv
dv/offset_sorted_multiset_check.sv
dv/offset_sorted_multiset_test.sv
